[rtl/sfl_pkg.sv]
// Package for the segregated free list allocator: sizing constants, status codes
// and the size class mapping shared by the RAM-based allocator and its users.
// Depends on nothing.
package sfl_pkg;

    localparam int LINEAR_CLASSES = 8;
    localparam int EXP_CLASSES    = 4;
    localparam int LIST_DEPTH     = 16;
    localparam int ADDR_WIDTH     = 20;

    localparam int FIELD_W     = 20;
    localparam int SIZE_W      = 20;
    localparam int NUM_CLASSES = LINEAR_CLASSES + EXP_CLASSES + 1;
    localparam int CLASS_W     = $clog2(NUM_CLASSES);
    localparam int FILL_W      = $clog2(LIST_DEPTH + 1);
    localparam int EXP_BASE    = $clog2(LINEAR_CLASSES + 1);

    localparam int LIN_DEPTH = LINEAR_CLASSES * LIST_DEPTH;
    localparam int SZ_DEPTH  = (EXP_CLASSES + 1) * LIST_DEPTH;
    localparam int LIN_AW    = $clog2(LIN_DEPTH);
    localparam int SZ_AW     = $clog2(SZ_DEPTH);
    localparam int SZ_WIDTH  = ADDR_WIDTH + SIZE_W;

    typedef logic [1:0]            status_t;
    typedef logic [CLASS_W-1:0]    class_t;
    typedef logic [FILL_W-1:0]     fill_t;
    typedef logic [ADDR_WIDTH-1:0] addr_t;
    typedef logic [SIZE_W-1:0]     size_t;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_NOFIT = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;
    localparam status_t STATUS_ZERO  = 2'd3;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    // Class of a block size; only meaningful for a nonzero size.
    function automatic class_t size_class(input size_t n);
        class_t c;
        c = class_t'(NUM_CLASSES - 1);
        for (int i = EXP_CLASSES - 1; i >= 0; i--) begin
            if (64'(n) <= (64'd1 << (EXP_BASE + i))) begin
                c = class_t'(LINEAR_CLASSES + i);
            end
        end
        if (32'(n) <= LINEAR_CLASSES) begin
            c = class_t'(32'(n) - 1);
        end
        return c;
    endfunction

endpackage

[rtl/sfl_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// Depends on nothing.
module sfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/segregated_free_list_allocator_unit.sv]
// Top level of the segregated free list allocator: the request sequencer, the
// per-class fill counters and two stack RAMs. Depends on sfl_pkg and sfl_ram.
//
// Usage: a transaction is offered by raising start with func, cell_addr and
// cell_count; it is taken at a rising edge where start is high and busy is low.
// func 1 releases the block at cell_addr of cell_count cells into its size
// class; func 0 allocates cell_count cells. Exactly one result follows each
// transaction: done is high for one cycle with block_addr and status, and the
// receiver cannot stall it, so the result must be captured in that cycle.
// Sequence: a zero-size request reports in the cycle after acceptance, a
// release after S_FILE. An allocate scans classes upward from its own class:
// an empty class takes S_SCAN only, an occupied class S_SCAN and S_CHECK,
// since each top block takes a read of the stack RAM with registered read
// data; re-filing a remainder adds S_RCLS and S_FILE. The worst case is
// twelve empty classes, then a hit in the catch-all class whose remainder is
// re-filed. Only one transaction is in flight, and busy falls in the cycle
// the result is shown, so a new transaction may be taken then. Reset clears
// all fill counters, which empties every class at once; the RAM contents are
// never read below a fill count and need no clearing.
module segregated_free_list_allocator_unit
    import sfl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                func,
    input  logic [FIELD_W-1:0]  cell_addr,
    input  logic [FIELD_W-1:0]  cell_count,
    output logic                done,
    output logic [FIELD_W-1:0]  block_addr,
    output status_t             status
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_RCLS  = 3'd3;
    localparam logic [2:0] S_FILE  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic               func_reg, func_next;
    size_t              count_reg, count_next;
    class_t             scan_reg, scan_next;
    addr_t              file_addr_reg, file_addr_next;
    size_t              file_size_reg, file_size_next;
    class_t             file_cls_reg, file_cls_next;
    addr_t              alloc_addr_reg, alloc_addr_next;
    logic               done_reg, done_next;
    status_t            status_reg, status_next;
    logic [FIELD_W-1:0] block_addr_reg, block_addr_next;
    fill_t              fill_reg [NUM_CLASSES];
    fill_t              fill_next [NUM_CLASSES];

    logic                lin_we, lin_re, sz_we, sz_re;
    logic [LIN_AW-1:0]   lin_waddr, lin_raddr;
    logic [SZ_AW-1:0]    sz_waddr, sz_raddr;
    addr_t               lin_rdata;
    logic [SZ_WIDTH-1:0] sz_wdata, sz_rdata;

    fill_t  scan_fill, file_fill;
    size_t  top_size;
    addr_t  top_addr;
    logic   scan_linear, file_linear, scan_last;

    sfl_ram #(.WIDTH(ADDR_WIDTH), .DEPTH(LIN_DEPTH)) u_lin_ram (
        .clk   (clk),
        .we    (lin_we),
        .waddr (lin_waddr),
        .wdata (file_addr_reg),
        .re    (lin_re),
        .raddr (lin_raddr),
        .rdata (lin_rdata)
    );

    sfl_ram #(.WIDTH(SZ_WIDTH), .DEPTH(SZ_DEPTH)) u_sz_ram (
        .clk   (clk),
        .we    (sz_we),
        .waddr (sz_waddr),
        .wdata (sz_wdata),
        .re    (sz_re),
        .raddr (sz_raddr),
        .rdata (sz_rdata)
    );

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign block_addr = block_addr_reg;
    assign status     = status_reg;

    assign scan_fill   = fill_reg[scan_reg];
    assign file_fill   = fill_reg[file_cls_reg];
    assign scan_linear = (32'(scan_reg) < LINEAR_CLASSES);
    assign file_linear = (32'(file_cls_reg) < LINEAR_CLASSES);
    assign scan_last   = (scan_reg == class_t'(NUM_CLASSES - 1));

    assign lin_raddr = LIN_AW'(32'(scan_reg) * LIST_DEPTH + 32'(scan_fill) - 1);
    assign sz_raddr  = SZ_AW'((32'(scan_reg) - LINEAR_CLASSES) * LIST_DEPTH
                              + 32'(scan_fill) - 1);
    assign lin_waddr = LIN_AW'(32'(file_cls_reg) * LIST_DEPTH + 32'(file_fill));
    assign sz_waddr  = SZ_AW'((32'(file_cls_reg) - LINEAR_CLASSES) * LIST_DEPTH
                              + 32'(file_fill));
    assign sz_wdata  = {file_size_reg, file_addr_reg};

    assign top_size = scan_linear ? (size_t'(scan_reg) + size_t'(1))
                                  : sz_rdata[SZ_WIDTH-1:ADDR_WIDTH];
    assign top_addr = scan_linear ? lin_rdata : sz_rdata[ADDR_WIDTH-1:0];

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        file_addr_next  = file_addr_reg;
        file_size_next  = file_size_reg;
        file_cls_next   = file_cls_reg;
        alloc_addr_next = alloc_addr_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        block_addr_next = block_addr_reg;
        fill_next       = fill_reg;
        lin_we          = 1'b0;
        lin_re          = 1'b0;
        sz_we           = 1'b0;
        sz_re           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    func_next      = func;
                    count_next     = cell_count;
                    scan_next      = size_class(cell_count);
                    file_cls_next  = size_class(cell_count);
                    file_addr_next = ADDR_WIDTH'(cell_addr);
                    file_size_next = cell_count;
                    if (cell_count == '0)
                    begin
                        done_next       = 1'b1;
                        status_next     = STATUS_ZERO;
                        block_addr_next = '0;
                    end
                    else if (func == FUNC_RELEASE)
                    begin
                        state_next = S_FILE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_fill == '0)
                begin
                    if (scan_last)
                    begin
                        done_next       = 1'b1;
                        status_next     = STATUS_NOFIT;
                        block_addr_next = '0;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        scan_next = scan_reg + class_t'(1);
                    end
                end
                else
                begin
                    lin_re     = scan_linear;
                    sz_re      = !scan_linear;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (top_size < count_reg)
                begin
                    if (scan_last)
                    begin
                        done_next       = 1'b1;
                        status_next     = STATUS_NOFIT;
                        block_addr_next = '0;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        scan_next  = scan_reg + class_t'(1);
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    fill_next[scan_reg] = scan_fill - fill_t'(1);
                    alloc_addr_next     = top_addr;
                    if (top_size > count_reg)
                    begin
                        file_addr_next = top_addr + ADDR_WIDTH'(count_reg);
                        file_size_next = top_size - count_reg;
                        state_next     = S_RCLS;
                    end
                    else
                    begin
                        done_next       = 1'b1;
                        status_next     = STATUS_OK;
                        block_addr_next = FIELD_W'(top_addr);
                        state_next      = S_IDLE;
                    end
                end
            end
            S_RCLS:
            begin
                file_cls_next = size_class(file_size_reg);
                state_next    = S_FILE;
            end
            S_FILE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (32'(file_fill) < LIST_DEPTH)
                begin
                    lin_we                  = file_linear;
                    sz_we                   = !file_linear;
                    fill_next[file_cls_reg] = file_fill + fill_t'(1);
                end
                if (func_reg == FUNC_RELEASE)
                begin
                    block_addr_next = '0;
                    status_next     = (32'(file_fill) < LIST_DEPTH) ? STATUS_OK
                                                                     : STATUS_FULL;
                end
                else
                begin
                    block_addr_next = FIELD_W'(alloc_addr_reg);
                    status_next     = STATUS_OK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        count_reg      <= count_next;
        scan_reg       <= scan_next;
        file_addr_reg  <= file_addr_next;
        file_size_reg  <= file_size_next;
        file_cls_reg   <= file_cls_next;
        alloc_addr_reg <= alloc_addr_next;
        status_reg     <= status_next;
        block_addr_reg <= block_addr_next;
    end

    // A result is only ever presented after the sequencer has returned to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while a transaction is still in progress");

    a_zero_size: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cell_count == '0) |=> done && (status == STATUS_ZERO))
        else $error("zero-size transaction did not report at once");

    a_nonzero_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cell_count != '0) |=> busy && !done)
        else $error("nonzero transaction did not occupy the sequencer");

    a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != STATUS_OK) |-> (block_addr == '0))
        else $error("failed transaction returned a nonzero address");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (32'(scan_fill) <= LIST_DEPTH))
        else $error("class fill count exceeds the list depth");

endmodule

[bench/tb_top.sv]
// Testbench for segregated_free_list_allocator_unit: random and directed allocate
// and release transactions checked against a free-list scoreboard with its own copy
// of the class stacks. Depends on sfl_pkg and the allocator RTL.
module tb_top
    import sfl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1000;

    class free_list_scoreboard;
        addr_t   lin_addr [LINEAR_CLASSES][LIST_DEPTH];
        addr_t   blk_addr [EXP_CLASSES+1][LIST_DEPTH];
        size_t   blk_size [EXP_CLASSES+1][LIST_DEPTH];
        int      fill [NUM_CLASSES];
        addr_t   exp_addr_q [$];
        status_t exp_status_q [$];
        int      errors;

        function new();
            foreach (fill[i]) fill[i] = 0;
            errors = 0;
        endfunction

        function int class_for(size_t n);
            int unsigned bound;
            if (int'(n) <= LINEAR_CLASSES) return int'(n) - 1;
            bound = 1 << $clog2(LINEAR_CLASSES + 1);
            for (int i = 0; i < EXP_CLASSES; i++) begin
                if (int'(n) <= (bound << i)) return LINEAR_CLASSES + i;
            end
            return NUM_CLASSES - 1;
        endfunction

        function bit push_block(addr_t a, size_t n);
            int c;
            c = class_for(n);
            if (fill[c] >= LIST_DEPTH) return 1'b0;
            if (c < LINEAR_CLASSES) begin
                lin_addr[c][fill[c]] = a;
            end
            else begin
                blk_addr[c-LINEAR_CLASSES][fill[c]] = a;
                blk_size[c-LINEAR_CLASSES][fill[c]] = n;
            end
            fill[c]++;
            return 1'b1;
        endfunction

        function void note_request(logic f, addr_t a, size_t n);
            addr_t   res_addr;
            status_t res_status;
            addr_t   top_a;
            size_t   top_n;
            bit      hit;
            int      c;
            res_addr = '0;
            res_status = STATUS_OK;
            hit = 1'b0;
            if (n == '0) begin
                res_status = STATUS_ZERO;
            end
            else if (f == FUNC_RELEASE) begin
                if (!push_block(a, n)) res_status = STATUS_FULL;
            end
            else begin
                for (c = class_for(n); c < NUM_CLASSES && !hit; c++) begin
                    if (fill[c] == 0) continue;
                    if (c < LINEAR_CLASSES) begin
                        top_a = lin_addr[c][fill[c]-1];
                        top_n = size_t'(c + 1);
                    end
                    else begin
                        top_a = blk_addr[c-LINEAR_CLASSES][fill[c]-1];
                        top_n = blk_size[c-LINEAR_CLASSES][fill[c]-1];
                    end
                    if (top_n < n) continue;
                    fill[c]--;
                    hit = 1'b1;
                    if (top_n > n) void'(push_block(addr_t'(top_a + n), size_t'(top_n - n)));
                    res_addr = top_a;
                end
                if (!hit) res_status = STATUS_NOFIT;
            end
            exp_addr_q.push_back(res_addr);
            exp_status_q.push_back(res_status);
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10) $display("%0t: %s", $realtime, msg);
        endfunction

        function void check_result(addr_t a, status_t s);
            addr_t   ea;
            status_t es;
            if (exp_addr_q.size() == 0) begin
                report($sformatf("result with nothing expected: block_addr %h status %0d", a, s));
                return;
            end
            ea = exp_addr_q.pop_front();
            es = exp_status_q.pop_front();
            if (s !== es) report($sformatf("status expected %0d actual %0d", es, s));
            if (a !== ea) report($sformatf("block_addr expected %h actual %h", ea, a));
        endfunction

        function int pending();
            return exp_addr_q.size();
        endfunction

        function void finish_check();
            if (exp_addr_q.size() != 0) begin
                report($sformatf("%0d expected results never arrived", exp_addr_q.size()));
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                func;
    logic [FIELD_W-1:0]  cell_addr;
    logic [FIELD_W-1:0]  cell_count;
    logic                done;
    logic [FIELD_W-1:0]  block_addr;
    status_t             status;

    free_list_scoreboard sb = new();
    int n_accepted = 0;
    int quiet = 0;
    int idle_pct = 0;

    segregated_free_list_allocator_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .cell_addr  (cell_addr),
        .cell_count (cell_count),
        .done       (done),
        .block_addr (block_addr),
        .status     (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            quiet++;
            if (start && !busy) begin
                sb.note_request(func, cell_addr, cell_count);
                n_accepted++;
                quiet = 0;
            end
            if (done) begin
                sb.check_result(block_addr, status);
                quiet = 0;
            end
            if (quiet >= QUIET_LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    task automatic send(logic f, logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] n);
        int target;
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 4))
                @(negedge clk);
        end
        start      <= 1'b1;
        func       <= f;
        cell_addr  <= a;
        cell_count <= n;
        target = n_accepted + 1;
        do @(negedge clk); while (n_accepted < target);
    endtask

    function automatic logic [FIELD_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return FIELD_W'($urandom_range(1, LINEAR_CLASSES));
        if (r < 80) return FIELD_W'($urandom_range(LINEAR_CLASSES + 1, 128));
        if (r < 92) return FIELD_W'($urandom_range(129, 4096));
        return FIELD_W'($urandom_range(1, (1 << FIELD_W) - 1));
    endfunction

    initial
    begin
        int rel_pct;
        logic [FIELD_W-1:0] burst_size;
        logic [FIELD_W-1:0] n;
        logic f;
        rst_n      = 1'b0;
        start      = 1'b0;
        func       = FUNC_ALLOC;
        cell_addr  = '0;
        cell_count = '0;
        rel_pct    = 50;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send(FUNC_ALLOC, 20'd0, 20'd0);
        send(FUNC_RELEASE, 20'd5, 20'd0);
        send(FUNC_ALLOC, 20'd0, 20'd1);
        send(FUNC_ALLOC, 20'hFFFFF, 20'hFFFFF);
        send(FUNC_RELEASE, 20'hFFFFF, 20'hFFFFF);
        send(FUNC_RELEASE, 20'd100, 20'd1);
        send(FUNC_RELEASE, 20'd200, 20'd8);
        send(FUNC_RELEASE, 20'd300, 20'd9);
        send(FUNC_RELEASE, 20'd400, 20'd16);
        send(FUNC_RELEASE, 20'd500, 20'd17);
        send(FUNC_RELEASE, 20'd600, 20'd128);
        send(FUNC_RELEASE, 20'd700, 20'd129);
        send(FUNC_ALLOC, 20'd0, 20'd1);
        send(FUNC_ALLOC, 20'd0, 20'd1);
        send(FUNC_ALLOC, 20'd0, 20'd10);
        send(FUNC_ALLOC, 20'd0, 20'd16);
        send(FUNC_ALLOC, 20'hFFFFF, 20'd129);
        send(FUNC_RELEASE, 20'hFFFF0, 20'd40);
        send(FUNC_ALLOC, 20'd0, 20'd20);
        send(FUNC_ALLOC, 20'd0, 20'd2000);
        send(FUNC_ALLOC, 20'd0, 20'hFFFFF);
        send(FUNC_RELEASE, 20'h12345, 20'hAAAAA);
        send(FUNC_RELEASE, 20'hAAAAA, 20'h55555);
        send(FUNC_ALLOC, 20'h55555, 20'h80000);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i < RANDOM_ITEMS / 3) idle_pct = 32;
            else if (i < 2 * RANDOM_ITEMS / 3) idle_pct = 71;
            else idle_pct = 0;
            if (i % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0: rel_pct = 15;
                    1: rel_pct = 50;
                    default: rel_pct = 85;
                endcase
            end
            if ($urandom_range(0, 99) < 2) begin
                burst_size = pick_size();
                repeat (18) send(FUNC_RELEASE, FIELD_W'($urandom()), burst_size);
            end
            f = ($urandom_range(0, 99) < rel_pct) ? FUNC_RELEASE : FUNC_ALLOC;
            n = ($urandom_range(0, 99) < 4) ? '0 : pick_size();
            send(f, FIELD_W'($urandom()), n);
        end
        start <= 1'b0;

        while (sb.pending() > 0) @(negedge clk);
        repeat (40) @(negedge clk);
        sb.finish_check();
        if (sb.errors == 0) begin
            $display("tb_top OK");
        end
        else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
